// ===== design/ioa_pkg.sv =====
// Shared types and constants for the interval overlap admission block.
package ioa_pkg;

    localparam int MAX_BOUNDARIES = 2048;
    localparam int TIME_BITS      = 32;
    localparam int DELTA_W        = 12;
    localparam int CNT_W          = $clog2(MAX_BOUNDARIES + 3);
    localparam int RUN_W          = DELTA_W + 1;
    localparam int LIMIT_W        = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_ORDER   = 2'd3
    } status_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]      tstamp;
        logic signed [DELTA_W-1:0] delta;
    } entry_t;

    typedef struct packed {
        logic ring_shift;
        logic cand_shift;
        logic commit;
    } cell_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } ctl_stat_t;

endpackage

// ===== design/interval_overlap_admission.sv =====
// An empty or reversed interval skips the sweep; a result waits on m_tvalid until m_tready takes it.
// For an ordered, non-empty interval the committed table rotates once around the 2048-cell boundary
// ring, while the candidate table is built on a second chain.
// Throughput: one request at a time; the next is taken once the sweep is done.
// Reset: synchronous active-low aresetn empties the table and sets max_overlap to 2.
// Top level of the interval overlap admission block.
module interval_overlap_admission (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // start_time [31:0], end_time [63:32]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // accepted [0], status [2:1], zero [7:3]
    input  logic                        cfg_wr_en,
    input  logic [ioa_pkg::LIMIT_W-1:0] cfg_wr_data
);

    localparam int N = ioa_pkg::MAX_BOUNDARIES;

    ioa_pkg::cell_ctrl_t ctrl;
    ioa_pkg::ctl_stat_t  stat;
    ioa_pkg::entry_t     tail;
    ioa_pkg::entry_t     ring_q [N];
    ioa_pkg::entry_t     cand_q [N];
    logic                res_accepted;
    ioa_pkg::status_t    res_status;
    logic                in_fire;

    assign s_tready = !stat.busy;
    assign in_fire  = s_tvalid && s_tready;

    ioa_ctl u_ctl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .in_start     (s_tdata[31:0]),
        .in_end       (s_tdata[63:32]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .head         (ring_q[0]),
        .res_ready    (m_tready),
        .res_valid    (m_tvalid),
        .res_accepted (res_accepted),
        .res_status   (res_status),
        .tail         (tail),
        .ctrl         (ctrl),
        .stat         (stat)
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        ioa_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .ring_in  ((i == N - 1) ? ring_q[0] : ring_q[(i + 1) % N]),
            .cand_in  ((i == N - 1) ? tail : cand_q[(i + 1) % N]),
            .ring_out (ring_q[i]),
            .cand_out (cand_q[i])
        );
    end

    assign m_tdata = {5'b0, res_status, res_accepted};

`ifndef SYNTHESIS
    a_acc_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == ioa_pkg::ST_OK)))
        else $error("accepted flag disagrees with status");
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken during a sweep");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= ioa_pkg::CNT_W'(N))
        else $error("boundary count beyond table size");
    a_commit_idle_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |-> (!ctrl.ring_shift && !ctrl.cand_shift))
        else $error("commit overlaps a shift");
`endif

endmodule

// ===== design/ioa_cell.sv =====
// One boundary cell: a committed entry on the ring and a candidate entry on the build chain.
module ioa_cell (
    input  logic                aclk,
    input  ioa_pkg::cell_ctrl_t ctrl,
    input  ioa_pkg::entry_t     ring_in,
    input  ioa_pkg::entry_t     cand_in,
    output ioa_pkg::entry_t     ring_out,
    output ioa_pkg::entry_t     cand_out
);

    ioa_pkg::entry_t committed_reg;
    ioa_pkg::entry_t candidate_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            committed_reg <= candidate_reg;
        end else if (ctrl.ring_shift) begin
            committed_reg <= ring_in;
        end
        if (ctrl.cand_shift) begin
            candidate_reg <= cand_in;
        end
    end

    assign ring_out = committed_reg;
    assign cand_out = candidate_reg;

endmodule

// ===== design/ioa_ctl.sv =====
// Merge and coverage controller that sweeps the boundary ring and builds the candidate table.
module ioa_ctl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic [ioa_pkg::TIME_BITS-1:0] in_start,
    input  logic [ioa_pkg::TIME_BITS-1:0] in_end,
    input  logic                          cfg_wr_en,
    input  logic [ioa_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  ioa_pkg::entry_t               head,
    input  logic                          res_ready,
    output logic                          res_valid,
    output logic                          res_accepted,
    output ioa_pkg::status_t              res_status,
    output ioa_pkg::entry_t               tail,
    output ioa_pkg::cell_ctrl_t           ctrl,
    output ioa_pkg::ctl_stat_t            stat
);

    localparam logic [ioa_pkg::CNT_W-1:0] NUM = ioa_pkg::CNT_W'(ioa_pkg::MAX_BOUNDARIES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_MERGE = 5'b00100,
        S_PAD   = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t                               state_reg, state_next;
    logic [ioa_pkg::TIME_BITS-1:0]        s_reg, e_reg;
    logic                                 s_done_reg, s_done_next;
    logic                                 e_done_reg, e_done_next;
    logic [ioa_pkg::CNT_W-1:0]            j_reg, j_next;
    logic [ioa_pkg::CNT_W-1:0]            k_reg, k_next;
    logic [ioa_pkg::CNT_W-1:0]            cs_reg, cs_next;
    logic [ioa_pkg::CNT_W-1:0]            count_reg, count_next;
    logic signed [ioa_pkg::RUN_W-1:0]     run_reg, run_next;
    logic                                 over_reg, over_next;
    logic                                 commit_reg, commit_next;
    ioa_pkg::status_t                     fin_reg, fin_next;
    logic [ioa_pkg::LIMIT_W-1:0]          limit_reg;
    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_acc_reg, out_acc_next;
    ioa_pkg::status_t                     out_st_reg, out_st_next;

    logic                                 old_av, new_av, take_old, take_new;
    logic [ioa_pkg::TIME_BITS-1:0]        new_t, sel_t;
    logic signed [ioa_pkg::DELTA_W-1:0]   new_d, sel_d;
    logic signed [ioa_pkg::RUN_W-1:0]     run_sum, limit_s;

    always_comb begin
        old_av   = (j_reg < count_reg);
        new_av   = !s_done_reg || !e_done_reg;
        new_t    = !s_done_reg ? s_reg : e_reg;
        new_d    = !s_done_reg ? ioa_pkg::DELTA_W'(1) : -ioa_pkg::DELTA_W'(1);
        take_old = old_av && (!new_av || (head.tstamp <= new_t));
        take_new = new_av && (!take_old || (new_t == head.tstamp));
        sel_t    = take_old ? head.tstamp : new_t;
        sel_d    = (take_old ? head.delta : '0) + (take_new ? new_d : '0);
        run_sum  = run_reg + ioa_pkg::RUN_W'(sel_d);
        limit_s  = $signed({{(ioa_pkg::RUN_W-ioa_pkg::LIMIT_W){1'b0}}, limit_reg});
    end

    always_comb begin
        state_next     = state_reg;
        s_done_next    = s_done_reg;
        e_done_next    = e_done_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cs_next        = cs_reg;
        count_next     = count_reg;
        run_next       = run_reg;
        over_next      = over_reg;
        commit_next    = commit_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_acc_next   = out_acc_reg;
        out_st_next    = out_st_reg;
        ctrl           = '0;
        tail.tstamp    = sel_t;
        tail.delta     = sel_d;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                s_done_next = 1'b0;
                e_done_next = 1'b0;
                j_next      = '0;
                k_next      = '0;
                cs_next     = '0;
                run_next    = '0;
                over_next   = 1'b0;
                commit_next = 1'b0;
                if (s_reg > e_reg) begin
                    fin_next   = ioa_pkg::ST_ORDER;
                    state_next = S_FIN;
                end else if (s_reg == e_reg) begin
                    fin_next   = ioa_pkg::ST_OK;
                    state_next = S_FIN;
                end else begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE: begin
                if (!old_av && !new_av) begin
                    state_next = S_PAD;
                end else begin
                    if (take_old) begin
                        ctrl.ring_shift = 1'b1;
                        j_next          = j_reg + 1'b1;
                    end
                    if (take_new) begin
                        if (!s_done_reg) begin
                            s_done_next = 1'b1;
                        end else begin
                            e_done_next = 1'b1;
                        end
                    end
                    if (sel_d != '0) begin
                        k_next   = k_reg + 1'b1;
                        run_next = run_sum;
                        if (run_sum > limit_s) begin
                            over_next = 1'b1;
                        end
                        if (cs_reg < NUM) begin
                            ctrl.cand_shift = 1'b1;
                            cs_next         = cs_reg + 1'b1;
                        end
                    end
                end
            end
            S_PAD: begin
                if (j_reg < NUM) begin
                    ctrl.ring_shift = 1'b1;
                    j_next          = j_reg + 1'b1;
                end
                if (cs_reg < NUM) begin
                    ctrl.cand_shift = 1'b1;
                    cs_next         = cs_reg + 1'b1;
                end
                if ((j_reg == NUM) && (cs_reg == NUM)) begin
                    state_next = S_FIN;
                    if (over_reg) begin
                        fin_next = ioa_pkg::ST_OVERLAP;
                    end else if (k_reg > NUM) begin
                        fin_next = ioa_pkg::ST_FULL;
                    end else begin
                        fin_next    = ioa_pkg::ST_OK;
                        commit_next = 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (!out_valid_reg || res_ready) begin
                    out_valid_next = 1'b1;
                    out_st_next    = fin_reg;
                    out_acc_next   = (fin_reg == ioa_pkg::ST_OK);
                    if (commit_reg) begin
                        ctrl.commit = 1'b1;
                        count_next  = k_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            limit_reg     <= ioa_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s_reg <= in_start;
            e_reg <= in_end;
        end
        s_done_reg  <= s_done_next;
        e_done_reg  <= e_done_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        cs_reg      <= cs_next;
        run_reg     <= run_next;
        over_reg    <= over_next;
        commit_reg  <= commit_next;
        fin_reg     <= fin_next;
        out_acc_reg <= out_acc_next;
        out_st_reg  <= out_st_next;
    end

    assign res_valid    = out_valid_reg;
    assign res_accepted = out_acc_reg;
    assign res_status   = out_st_reg;
    assign stat.busy    = (state_reg != S_IDLE);
    assign stat.count   = count_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the interval overlap admission block.
module testbench;

    localparam int CYCLE_LIMIT = 12_000_000;

    typedef struct packed {
        logic [31:0] end_t;
        logic [31:0] start_t;
    } request_t;

    typedef struct packed {
        logic             accepted;
        ioa_pkg::status_t status;
    } verdict_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [63:0]                 s_tdata = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [7:0]                  m_tdata;
    logic                        cfg_wr_en = 1'b0;
    logic [ioa_pkg::LIMIT_W-1:0] cfg_wr_data = '0;

    request_t            pending_requests[$];
    verdict_t            expected_verdicts[$];
    logic signed [11:0]  coverage_delta[logic [31:0]];
    logic [3:0]          overlap_limit = ioa_pkg::LIMIT_RESET;
    logic                send_hold = 1'b0;
    int                  send_idle_pct = 32;
    int                  recv_idle_pct = 63;
    int                  mismatches = 0;
    int                  results_seen = 0;
    int                  admitted = 0;
    int                  status_seen[4] = '{0, 0, 0, 0};
    longint              cycles = 0;

    interval_overlap_admission DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Sweeps the boundary table with the new interval merged in and commits it if admitted.
    function automatic verdict_t admit_interval(request_t req);
        logic signed [11:0] cand[logic [31:0]];
        logic [31:0]        t;
        int                 running;
        logic               over;
        verdict_t           v;
        if (req.start_t > req.end_t) begin
            v = '{1'b0, ioa_pkg::ST_ORDER};
            return v;
        end
        if (req.start_t == req.end_t) begin
            v = '{1'b1, ioa_pkg::ST_OK};
            return v;
        end
        cand = coverage_delta;
        cand[req.start_t] = cand.exists(req.start_t) ? cand[req.start_t] + 12'sd1 : 12'sd1;
        cand[req.end_t] = cand.exists(req.end_t) ? cand[req.end_t] - 12'sd1 : -12'sd1;
        if (cand[req.start_t] == 0) cand.delete(req.start_t);
        if (cand[req.end_t] == 0) cand.delete(req.end_t);
        running = 0;
        over = 1'b0;
        if (cand.first(t)) begin
            do begin
                running += int'(cand[t]);
                if (running > int'(overlap_limit)) over = 1'b1;
            end while (cand.next(t));
        end
        if (over) begin
            v = '{1'b0, ioa_pkg::ST_OVERLAP};
        end else if (cand.num() > ioa_pkg::MAX_BOUNDARIES) begin
            v = '{1'b0, ioa_pkg::ST_FULL};
        end else begin
            coverage_delta = cand;
            v = '{1'b1, ioa_pkg::ST_OK};
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_verdicts.push_back(admit_interval(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_tdata <= pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transfer %h", m_tdata);
                end else begin
                    want = expected_verdicts.pop_front();
                    status_seen[want.status]++;
                    if (want.accepted) admitted++;
                    if (m_tdata[0] !== want.accepted || m_tdata[2:1] !== want.status ||
                        m_tdata[7:3] !== 5'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch at result %0d: ",
                                      "expected accepted=%0b status=%s, got %h"},
                                     results_seen, want.accepted, want.status.name(),
                                     m_tdata);
                    end
                end
            end
        end
    end

    task automatic drain_all();
        while (pending_requests.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_limit(logic [3:0] value);
        drain_all();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        overlap_limit = value;
        @(posedge aclk);
    endtask

    task automatic queue_request(logic [31:0] s, logic [31:0] e);
        pending_requests.push_back('{e, s});
    endtask

    task automatic queue_random(int count, logic [31:0] window);
        logic [31:0] base;
        logic [31:0] s;
        base = $urandom;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(19) == 0) base = $urandom_range(32'hFFFF_F000);
            case ($urandom_range(9))
                0: queue_request($urandom, $urandom);
                1: begin
                    s = base + $urandom_range(window);
                    queue_request(s, s - $urandom_range(1, 5));
                end
                2: begin
                    s = base + $urandom_range(window);
                    queue_request(s, s);
                end
                default: begin
                    s = base + $urandom_range(window);
                    queue_request(s, s + $urandom_range(1, 40));
                end
            endcase
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed checks at the default limit of two.
        queue_request(32'd10, 32'd20);
        queue_request(32'd15, 32'd25);
        queue_request(32'd18, 32'd19);
        queue_request(32'd20, 32'd25);
        queue_request(32'd20, 32'd21);
        queue_request(32'd30, 32'd30);
        queue_request(32'd40, 32'd39);
        queue_request(32'hFFFF_FFFF, 32'd0);
        queue_request(32'd0, 32'hFFFF_FFFF);
        queue_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(32'd0, 32'd0);
        queue_request(32'hAAAA_AAAA, 32'h5555_5555);
        queue_request(32'h5555_5555, 32'hAAAA_AAAA);
        write_limit(4'd0);
        queue_request(32'd100, 32'd101);
        queue_request(32'd5, 32'd5);
        queue_request(32'd7, 32'd3);
        write_limit(4'd1);
        queue_request(32'd200, 32'd300);
        queue_request(32'd250, 32'd260);
        write_limit(4'd15);
        queue_request(32'd250, 32'd260);
        queue_request(32'd250, 32'd260);

        queue_random(300, 32'd300);
        write_limit(4'd3);
        queue_random(150, 32'd200);
        drain_all();

        send_idle_pct = 63;
        recv_idle_pct = 32;
        write_limit(4'd1);
        queue_random(120, 32'd400);
        write_limit(4'd2);
        queue_random(150, 32'd150);
        drain_all();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(4'd8);
        queue_random(100, 32'd100);
        repeat (20000) @(posedge aclk);
        send_hold = 1'b1;
        while (s_tvalid || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        send_hold = 1'b0;
        write_limit(4'd15);
        queue_random(150, 32'd100);

        drain_all();
        repeat (2100) @(posedge aclk);
        $display("Covered %0d results: %0d admitted, %0d over limit, %0d full, %0d reversed.",
                 results_seen, admitted, status_seen[ioa_pkg::ST_OVERLAP],
                 status_seen[ioa_pkg::ST_FULL], status_seen[ioa_pkg::ST_ORDER]);
        $display("Limits 0, 1, 2, 3, 8 and 15 were exercised under three idle patterns.");
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_verdicts.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
